// ----- rtl/atf_pkg.sv -----
`timescale 1ns / 1ps
// Types, codes and constant tables shared by the affine transform accumulator.
package atf_pkg;

  localparam int XW            = 34;  // CORDIC x/y, sine and cosine (Q30 plus headroom)
  localparam int ZW            = 40;  // CORDIC angle in Q30 degrees
  localparam int PW            = 66;  // product of the shared multiplier
  localparam int AW            = 70;  // multiply-add accumulator
  localparam int MAX_STEPS     = 32;
  localparam int HALF_TURN_DEG = 180;

  localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  // atan(2^-i) in Q30 degrees
  localparam logic [ZW-1:0] ATAN_DEG_Q30 [MAX_STEPS] = '{
    40'd48318382080, 40'd28524006506, 40'd15071301663, 40'd7650428051,
    40'd3840059796,  40'd1921901881,  40'd961185452,   40'd480622056,
    40'd240314695,   40'd120157806,   40'd60078960,    40'd30039487,
    40'd15019745,    40'd7509872,     40'd3754936,     40'd1877468,
    40'd938734,      40'd469367,      40'd234684,      40'd117342,
    40'd58671,       40'd29335,       40'd14668,       40'd7334,
    40'd3667,        40'd1833,        40'd917,         40'd458,
    40'd229,         40'd115,         40'd57,          40'd29
  };

  typedef enum logic [3:0] {
    OP_IDENTITY  = 4'd0,
    OP_TRANSLATE = 4'd1,
    OP_SCALE     = 4'd2,
    OP_ROTATE    = 4'd3,
    OP_XSKEW     = 4'd4,
    OP_YSKEW     = 4'd5,
    OP_MIRROR_H  = 4'd6,
    OP_MIRROR_V  = 4'd7,
    OP_MATRIX    = 4'd8,
    OP_POINT     = 4'd9
  } atf_op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CORD, ST_ROUND, ST_DIV, ST_MAC0, ST_MAC1, ST_MAC2, ST_MAC3, ST_DONE
  } atf_state_e;

  typedef enum logic [1:0] {
    MD_APPLY, MD_POINT, MD_ROT
  } atf_mode_e;

  typedef enum logic [2:0] {
    CS_IDLE, CS_RED, CS_WRAP, CS_FOLD, CS_ITER, CS_DONE
  } atf_cordic_state_e;

  typedef enum logic [1:0] {
    DV_IDLE, DV_RUN, DV_FIN
  } atf_div_state_e;

  typedef struct packed {
    logic mul;   // capture a new product
    logic load;  // load the accumulator with the start value
    logic add;   // add the held product
    logic full;  // full products and Q.F rounding, else halved products
  } atf_mac_ctl_t;

  typedef struct packed {
    logic [3:0]         operation;
    logic signed [31:0] arg_a;
    logic signed [31:0] arg_b;
    logic signed [31:0] arg_c;
    logic signed [31:0] arg_d;
    logic signed [31:0] arg_e;
    logic signed [31:0] arg_f;
  } atf_in_t;

  typedef struct packed {
    logic signed [31:0] m_xx;
    logic signed [31:0] m_xy;
    logic signed [31:0] m_tx;
    logic signed [31:0] m_yx;
    logic signed [31:0] m_yy;
    logic signed [31:0] m_ty;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               error;
  } atf_out_t;

endpackage

// ----- rtl/atf_cordic.sv -----
`timescale 1ns / 1ps
// Angle reduction and iterative CORDIC giving Q30 sine and cosine of a Q.F degree angle.
module atf_cordic #(
  parameter int FRACTION_BITS = 16,
  parameter int CORDIC_STEPS  = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [31:0]              angle_i,
  output logic                            done_o,
  output logic signed [atf_pkg::XW-1:0]   sin_o,
  output logic signed [atf_pkg::XW-1:0]   cos_o
);

  localparam int XW        = atf_pkg::XW;
  localparam int ZW        = atf_pkg::ZW;
  localparam int SH        = 30 - FRACTION_BITS;
  localparam int MW        = 56;
  // a full turn is 45 * 2^(F+3) in Q.F degrees
  localparam int LB        = FRACTION_BITS + 3;
  localparam logic [31:0] RECIP_45 = 32'd95443718;  // ceil(2^32 / 45)
  localparam logic signed [ZW-1:0] FULL_Z = ZW'(2 * atf_pkg::HALF_TURN_DEG) << FRACTION_BITS;
  localparam logic signed [ZW-1:0] HALF_Z = ZW'(atf_pkg::HALF_TURN_DEG) << FRACTION_BITS;
  localparam logic signed [ZW-1:0] QUARTER = ZW'(atf_pkg::HALF_TURN_DEG / 2) << 30;
  localparam logic signed [ZW-1:0] TWO_Q   = ZW'(atf_pkg::HALF_TURN_DEG) << 30;

  atf_pkg::atf_cordic_state_e state_q, state_d;
  logic [MW-1:0]          mag_q, mag_d;
  logic                   neg_q, neg_d, flip_q, flip_d;
  logic [4:0]             it_q, it_d;
  logic signed [XW-1:0]   x_q, x_d, y_q, y_d, dx_v, dy_v;
  logic signed [ZW-1:0]   z_q, z_d, r_v, zs_v, at_v;
  logic signed [32:0]     ang_v;
  logic [32:0]            abs_v;
  logic [20:0]            hi_v, q_v, rem_v;
  logic [52:0]            qp_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= atf_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    flip_q <= flip_d;
    it_q   <= it_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    flip_d  = flip_q;
    it_d    = it_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    ang_v   = {angle_i[31], angle_i};
    abs_v   = ang_v[32] ? 33'(-ang_v) : 33'(ang_v);
    r_v     = '0;
    zs_v    = '0;
    hi_v    = '0;
    q_v     = '0;
    rem_v   = '0;
    qp_v    = '0;
    dx_v    = y_q >>> it_q;
    dy_v    = x_q >>> it_q;
    at_v    = $signed(atf_pkg::ATAN_DEG_Q30[it_q]);
    unique case (state_q)
      atf_pkg::CS_IDLE: begin
        if (start_i) begin
          neg_d   = angle_i[31];
          mag_d   = MW'(abs_v);
          state_d = atf_pkg::CS_RED;
        end
      end
      atf_pkg::CS_RED: begin
        // |angle| mod 360: keep the low bits, take the upper part mod 45 by reciprocal
        hi_v    = 21'(mag_q >> LB);
        qp_v    = 53'(hi_v) * 53'(RECIP_45);
        q_v     = 21'(qp_v >> 32);
        rem_v   = hi_v - 21'(q_v * 21'd45);
        mag_d   = (MW'(rem_v) << LB) | MW'(mag_q[LB-1:0]);
        state_d = atf_pkg::CS_WRAP;
      end
      atf_pkg::CS_WRAP: begin
        r_v = $signed(mag_q[ZW-1:0]);
        if (neg_q) begin
          r_v = -r_v;
        end
        if (r_v >= HALF_Z) begin
          r_v = r_v - FULL_Z;
        end else if (r_v < -HALF_Z) begin
          r_v = r_v + FULL_Z;
        end
        z_d     = r_v;
        state_d = atf_pkg::CS_FOLD;
      end
      atf_pkg::CS_FOLD: begin
        // fold into +-90 degrees, negate the results later
        zs_v   = z_q <<< SH;
        flip_d = 1'b0;
        if (zs_v > QUARTER) begin
          zs_v   = zs_v - TWO_Q;
          flip_d = 1'b1;
        end else if (zs_v < -QUARTER) begin
          zs_v   = zs_v + TWO_Q;
          flip_d = 1'b1;
        end
        z_d     = zs_v;
        x_d     = atf_pkg::CORDIC_GAIN_Q30;
        y_d     = '0;
        it_d    = '0;
        state_d = atf_pkg::CS_ITER;
      end
      atf_pkg::CS_ITER: begin
        if (!z_q[ZW-1]) begin
          x_d = x_q - dx_v;
          y_d = y_q + dy_v;
          z_d = z_q - at_v;
        end else begin
          x_d = x_q + dx_v;
          y_d = y_q - dy_v;
          z_d = z_q + at_v;
        end
        it_d = it_q + 5'd1;
        if (it_q == 5'(CORDIC_STEPS - 1)) begin
          state_d = atf_pkg::CS_DONE;
        end
      end
      atf_pkg::CS_DONE: begin
        state_d = atf_pkg::CS_IDLE;
      end
      default: begin
        state_d = atf_pkg::CS_IDLE;
      end
    endcase
  end

  assign done_o = (state_q == atf_pkg::CS_DONE);
  assign sin_o  = flip_q ? -y_q : y_q;
  assign cos_o  = flip_q ? -x_q : x_q;

endmodule

// ----- rtl/atf_div.sv -----
`timescale 1ns / 1ps
// Bit-serial signed divider for the skew tangent, truncating and saturating to 32 bits.
module atf_div #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [atf_pkg::XW-1:0] num_i,
  input  logic signed [atf_pkg::XW-1:0] den_i,
  output logic                          done_o,
  output logic signed [31:0]            quo_o
);

  localparam int XW = atf_pkg::XW;
  localparam int NW = 64;
  localparam logic [NW-1:0] POS_MAX = NW'(32'h7fff_ffff);
  localparam logic [NW-1:0] NEG_MAX = NW'(33'h0_8000_0000);

  atf_pkg::atf_div_state_e state_q, state_d;
  logic [NW-1:0] nq_q, nq_d;
  logic [XW-1:0] rem_q, rem_d, den_q, den_d, an_v, ad_v;
  logic [XW:0]   trial_v;
  logic          neg_q, neg_d;
  logic [5:0]    cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= atf_pkg::DV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q  <= nq_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
    cnt_q <= cnt_d;
  end

  always_comb begin
    state_d = state_q;
    nq_d    = nq_q;
    rem_d   = rem_q;
    den_d   = den_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    an_v    = num_i[XW-1] ? XW'(-num_i) : XW'(num_i);
    ad_v    = den_i[XW-1] ? XW'(-den_i) : XW'(den_i);
    trial_v = {rem_q, nq_q[NW-1]};
    unique case (state_q)
      atf_pkg::DV_IDLE: begin
        if (start_i) begin
          nq_d    = NW'(an_v) << FRACTION_BITS;
          den_d   = ad_v;
          rem_d   = '0;
          neg_d   = num_i[XW-1] ^ den_i[XW-1];
          cnt_d   = '0;
          state_d = atf_pkg::DV_RUN;
        end
      end
      atf_pkg::DV_RUN: begin
        // shift one dividend bit in, one quotient bit out
        if (trial_v >= {1'b0, den_q}) begin
          rem_d = XW'(trial_v - {1'b0, den_q});
          nq_d  = {nq_q[NW-2:0], 1'b1};
        end else begin
          rem_d = trial_v[XW-1:0];
          nq_d  = {nq_q[NW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(NW - 1)) begin
          state_d = atf_pkg::DV_FIN;
        end
      end
      atf_pkg::DV_FIN: begin
        state_d = atf_pkg::DV_IDLE;
      end
      default: begin
        state_d = atf_pkg::DV_IDLE;
      end
    endcase
  end

  always_comb begin
    if (neg_q) begin
      quo_o = (nq_q > NEG_MAX) ? 32'sh8000_0000 : -$signed(nq_q[31:0]);
    end else begin
      quo_o = (nq_q > POS_MAX) ? 32'sh7fff_ffff : $signed(nq_q[31:0]);
    end
  end

  assign done_o = (state_q == atf_pkg::DV_FIN);

endmodule

// ----- rtl/atf_mac.sv -----
`timescale 1ns / 1ps
// Shared multiplier with accumulator, rounding and 32-bit saturation.
module atf_mac #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk_i,
  input  atf_pkg::atf_mac_ctl_t         ctl_i,
  input  logic signed [atf_pkg::XW-1:0] a_i,
  input  logic signed [31:0]            b_i,
  input  logic signed [atf_pkg::AW-1:0] init_i,
  output logic signed [31:0]            res_o
);

  localparam int AW = atf_pkg::AW;
  localparam int PW = atf_pkg::PW;
  localparam logic signed [AW-1:0] RND_F = AW'(1) << (FRACTION_BITS - 1);
  localparam logic signed [AW-1:0] RND_H = AW'(1) << (FRACTION_BITS - 2);
  localparam logic signed [AW-1:0] S_MAX = AW'(32'sh7fff_ffff);
  localparam logic signed [AW-1:0] S_MIN = AW'(-64'sd2147483648);

  logic signed [PW-1:0] p_q;
  logic signed [AW-1:0] acc_q, acc_d, rnd_v;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      p_q <= a_i * b_i;
    end
    acc_q <= acc_d;
  end

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.load) begin
      acc_d = init_i;
    end else if (ctl_i.add) begin
      acc_d = acc_q + (ctl_i.full ? AW'(p_q) : AW'(p_q >>> 1));
    end
  end

  always_comb begin
    if (ctl_i.full) begin
      rnd_v = (acc_q + RND_F) >>> FRACTION_BITS;
    end else begin
      rnd_v = (acc_q + RND_H) >>> (FRACTION_BITS - 1);
    end
    if (rnd_v > S_MAX) begin
      res_o = 32'sh7fff_ffff;
    end else if (rnd_v < S_MIN) begin
      res_o = 32'sh8000_0000;
    end else begin
      res_o = rnd_v[31:0];
    end
  end

endmodule

// ----- rtl/affine_transform_accumulator.sv -----
`timescale 1ns / 1ps
// Top level: sequencer, matrix state and output register of the affine accumulator.
//
//  channel | signals                           | direction | beat
//  --------+-----------------------------------+-----------+-------------------------------
//  in      | in_valid_i, in_stall_o, in_data_i | to block  | one command, operation + args
//  out     | out_valid_o, out_stall_i, out_data_o | from block | matrix, point and error flag
//
// One command at a time; in_stall_o is high from acceptance until the result is
// handed to the output register. Matrix commands run their six entries one after
// another through the MAC0 to MAC3 states of the one shared multiplier. Rotate adds
// the angle reduction and fold, CORDIC_STEPS iterations and the two translation
// terms; skew adds CORDIC and the bit-serial divide. A stalled output holds the
// sequencer in its last state. Reset puts the matrix to identity and empties the
// output register.
module affine_transform_accumulator #(
  parameter int CORDIC_STEPS  = 24,
  parameter int FRACTION_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  atf_pkg::atf_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output atf_pkg::atf_out_t out_data_o
);

  localparam int XW = atf_pkg::XW;
  localparam int AW = atf_pkg::AW;
  localparam int SH = 30 - FRACTION_BITS;
  localparam logic signed [XW-1:0] ONE    = XW'(1) <<< FRACTION_BITS;
  localparam logic signed [31:0]   ONE32  = 32'(1) <<< FRACTION_BITS;
  localparam logic signed [XW:0]   RH     = (XW + 1)'((1 << SH) >> 1);
  localparam logic [XW-1:0]        MIN_CS = XW'(1) << SH;

  atf_pkg::atf_state_e state_q, state_d;
  atf_pkg::atf_mode_e  mode_q, mode_d;
  logic [2:0]          k_q, k_d;
  atf_pkg::atf_in_t    in_q, in_d;
  logic signed [31:0]  m_q [6];
  logic signed [31:0]  m_d [6];
  logic signed [31:0]  r_q [6];
  logic signed [31:0]  r_d [6];
  logic signed [XW-1:0] t_q [6];
  logic signed [XW-1:0] t_d [6];
  logic signed [31:0]  px_q, px_d, py_q, py_d;
  logic                err_q, err_d;
  atf_pkg::atf_out_t   out_q, out_d;
  logic                out_valid_q, out_valid_d, load_out;

  logic                cor_start, cor_done, div_start, div_done;
  logic signed [XW-1:0] sin_v, cos_v;
  logic signed [31:0]  quo_v, res_v;
  atf_pkg::atf_mac_ctl_t mac_ctl;
  logic signed [XW-1:0] a0_v, a1_v, mul_a, e_v;
  logic signed [31:0]  b0_v, b1_v, mul_b;
  logic signed [AW-1:0] init_v;
  logic signed [XW:0]  cr_v, sr_v;
  logic [XW-1:0]       acs_v;
  logic signed [32:0]  two_a;
  logic signed [XW-1:0] sat2a;
  atf_pkg::atf_op_e    op_v, opq_v;

  // The angle is taken straight from the accepted beat at the start edge
  atf_cordic #(
    .FRACTION_BITS (FRACTION_BITS),
    .CORDIC_STEPS  (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (in_data_i.arg_a),
    .done_o  (cor_done),
    .sin_o   (sin_v),
    .cos_o   (cos_v)
  );

  atf_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sin_v),
    .den_i   (cos_v),
    .done_o  (div_done),
    .quo_o   (quo_v)
  );

  atf_mac #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .ctl_i  (mac_ctl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .init_i (init_v),
    .res_o  (res_v)
  );

  // Control and matrix state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= atf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      m_q[0]      <= ONE32;
      m_q[1]      <= '0;
      m_q[2]      <= '0;
      m_q[3]      <= '0;
      m_q[4]      <= ONE32;
      m_q[5]      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      m_q         <= m_d;
    end
  end

  // Working payload, no reset needed
  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    k_q    <= k_d;
    in_q   <= in_d;
    r_q    <= r_d;
    t_q    <= t_d;
    px_q   <= px_d;
    py_q   <= py_d;
    err_q  <= err_d;
    out_q  <= out_d;
  end

  // Operand selection for the shared multiply-add
  always_comb begin
    a0_v = '0;
    a1_v = '0;
    b0_v = '0;
    b1_v = '0;
    e_v  = '0;
    unique case (mode_q)
      atf_pkg::MD_APPLY: begin
        case (k_q)
          3'd0: begin
            a0_v = t_q[0]; b0_v = m_q[0]; a1_v = t_q[1]; b1_v = m_q[3];
          end
          3'd1: begin
            a0_v = t_q[0]; b0_v = m_q[1]; a1_v = t_q[1]; b1_v = m_q[4];
          end
          3'd2: begin
            a0_v = t_q[0]; b0_v = m_q[2]; a1_v = t_q[1]; b1_v = m_q[5]; e_v = t_q[2];
          end
          3'd3: begin
            a0_v = t_q[3]; b0_v = m_q[0]; a1_v = t_q[4]; b1_v = m_q[3];
          end
          3'd4: begin
            a0_v = t_q[3]; b0_v = m_q[1]; a1_v = t_q[4]; b1_v = m_q[4];
          end
          3'd5: begin
            a0_v = t_q[3]; b0_v = m_q[2]; a1_v = t_q[4]; b1_v = m_q[5]; e_v = t_q[5];
          end
          default: begin
            a0_v = '0;
          end
        endcase
      end
      atf_pkg::MD_POINT: begin
        b0_v = in_q.arg_a;
        b1_v = in_q.arg_b;
        if (k_q[0]) begin
          a0_v = XW'(m_q[3]); a1_v = XW'(m_q[4]); e_v = XW'(m_q[5]);
        end else begin
          a0_v = XW'(m_q[0]); a1_v = XW'(m_q[1]); e_v = XW'(m_q[2]);
        end
      end
      atf_pkg::MD_ROT: begin
        // t0 holds cos, t1 -sin, t3 sin of the rounded rotation
        b0_v = in_q.arg_b;
        b1_v = in_q.arg_c;
        if (k_q[0]) begin
          a0_v = t_q[1]; a1_v = -t_q[0];
        end else begin
          a0_v = -t_q[0]; a1_v = t_q[3];
        end
      end
      default: begin
        a0_v = '0;
      end
    endcase
    mul_a = (state_q == atf_pkg::ST_MAC1) ? a1_v : a0_v;
    mul_b = (state_q == atf_pkg::ST_MAC1) ? b1_v : b0_v;
    if (mode_q == atf_pkg::MD_ROT) begin
      init_v = k_q[0] ? (AW'(in_q.arg_c) <<< FRACTION_BITS)
                      : (AW'(in_q.arg_b) <<< FRACTION_BITS);
    end else begin
      init_v = AW'(e_v) <<< (FRACTION_BITS - 1);
    end
    mac_ctl.mul  = (state_q == atf_pkg::ST_MAC0) || (state_q == atf_pkg::ST_MAC1);
    mac_ctl.load = (state_q == atf_pkg::ST_MAC0);
    mac_ctl.add  = (state_q == atf_pkg::ST_MAC1) || (state_q == atf_pkg::ST_MAC2);
    mac_ctl.full = (mode_q == atf_pkg::MD_ROT);
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    k_d       = k_q;
    in_d      = in_q;
    m_d       = m_q;
    r_d       = r_q;
    t_d       = t_q;
    px_d      = px_q;
    py_d      = py_q;
    err_d     = err_q;
    cor_start = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    op_v      = atf_pkg::atf_op_e'(in_data_i.operation);
    opq_v     = atf_pkg::atf_op_e'(in_q.operation);
    two_a     = {in_data_i.arg_a, 1'b0};
    sat2a     = XW'(in_data_i.arg_a[31] == in_data_i.arg_a[30] ? $signed(two_a[31:0]) :
                   (in_data_i.arg_a[31] ? 32'sh8000_0000 : 32'sh7fff_ffff));
    cr_v      = $signed({cos_v[XW-1], cos_v} + RH) >>> SH;
    sr_v      = $signed({sin_v[XW-1], sin_v} + RH) >>> SH;
    acs_v     = cos_v[XW-1] ? XW'(-cos_v) : XW'(cos_v);
    unique case (state_q)
      atf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          in_d   = in_data_i;
          px_d   = '0;
          py_d   = '0;
          err_d  = 1'b0;
          k_d    = '0;
          mode_d = atf_pkg::MD_APPLY;
          for (int i = 0; i < 6; i++) begin
            t_d[i] = '0;
          end
          t_d[0]  = ONE;
          t_d[4]  = ONE;
          state_d = atf_pkg::ST_MAC0;
          unique case (op_v) inside
            atf_pkg::OP_IDENTITY: begin
              m_d[0]  = ONE32;
              m_d[1]  = '0;
              m_d[2]  = '0;
              m_d[3]  = '0;
              m_d[4]  = ONE32;
              m_d[5]  = '0;
              state_d = atf_pkg::ST_DONE;
            end
            atf_pkg::OP_TRANSLATE: begin
              t_d[2] = XW'(in_data_i.arg_a);
              t_d[5] = XW'(in_data_i.arg_b);
            end
            atf_pkg::OP_SCALE: begin
              t_d[0] = XW'(in_data_i.arg_a);
              t_d[4] = XW'(in_data_i.arg_b);
            end
            atf_pkg::OP_ROTATE, atf_pkg::OP_XSKEW, atf_pkg::OP_YSKEW: begin
              cor_start = 1'b1;
              state_d   = atf_pkg::ST_CORD;
            end
            atf_pkg::OP_MIRROR_H: begin
              t_d[4] = -ONE;
              t_d[5] = sat2a;
            end
            atf_pkg::OP_MIRROR_V: begin
              t_d[0] = -ONE;
              t_d[2] = sat2a;
            end
            atf_pkg::OP_MATRIX: begin
              t_d[0] = XW'(in_data_i.arg_a);
              t_d[1] = XW'(in_data_i.arg_b);
              t_d[2] = XW'(in_data_i.arg_c);
              t_d[3] = XW'(in_data_i.arg_d);
              t_d[4] = XW'(in_data_i.arg_e);
              t_d[5] = XW'(in_data_i.arg_f);
            end
            atf_pkg::OP_POINT: begin
              mode_d = atf_pkg::MD_POINT;
            end
            default: begin
              err_d   = 1'b1;
              state_d = atf_pkg::ST_DONE;
            end
          endcase
        end
      end
      atf_pkg::ST_CORD: begin
        if (cor_done) begin
          state_d = atf_pkg::ST_ROUND;
        end
      end
      atf_pkg::ST_ROUND: begin
        if (opq_v == atf_pkg::OP_ROTATE) begin
          t_d[0]  = cr_v[XW-1:0];
          t_d[4]  = cr_v[XW-1:0];
          t_d[3]  = sr_v[XW-1:0];
          t_d[1]  = -sr_v[XW-1:0];
          mode_d  = atf_pkg::MD_ROT;
          k_d     = '0;
          state_d = atf_pkg::ST_MAC0;
        end else if (acs_v < MIN_CS) begin
          // cosine too close to zero: refuse the skew
          err_d   = 1'b1;
          state_d = atf_pkg::ST_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = atf_pkg::ST_DIV;
        end
      end
      atf_pkg::ST_DIV: begin
        if (div_done) begin
          if (opq_v == atf_pkg::OP_XSKEW) begin
            t_d[1] = XW'(quo_v);
          end else begin
            t_d[3] = XW'(quo_v);
          end
          mode_d  = atf_pkg::MD_APPLY;
          k_d     = '0;
          state_d = atf_pkg::ST_MAC0;
        end
      end
      atf_pkg::ST_MAC0: begin
        state_d = atf_pkg::ST_MAC1;
      end
      atf_pkg::ST_MAC1: begin
        state_d = atf_pkg::ST_MAC2;
      end
      atf_pkg::ST_MAC2: begin
        state_d = atf_pkg::ST_MAC3;
      end
      atf_pkg::ST_MAC3: begin
        k_d     = k_q + 3'd1;
        state_d = atf_pkg::ST_MAC0;
        unique case (mode_q)
          atf_pkg::MD_APPLY: begin
            r_d[k_q] = res_v;
            if (k_q == 3'd5) begin
              m_d     = r_d;
              state_d = atf_pkg::ST_DONE;
            end
          end
          atf_pkg::MD_POINT: begin
            if (k_q[0]) begin
              py_d    = res_v;
              state_d = atf_pkg::ST_DONE;
            end else begin
              px_d = res_v;
            end
          end
          atf_pkg::MD_ROT: begin
            if (k_q[0]) begin
              t_d[5] = XW'(res_v);
              mode_d = atf_pkg::MD_APPLY;
              k_d    = '0;
            end else begin
              t_d[2] = XW'(res_v);
            end
          end
          default: begin
            state_d = atf_pkg::ST_DONE;
          end
        endcase
      end
      atf_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = atf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = atf_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register: hold while stalled, drop the beat once taken
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (load_out) begin
      out_valid_d     = 1'b1;
      out_d.m_xx      = m_q[0];
      out_d.m_xy      = m_q[1];
      out_d.m_tx      = m_q[2];
      out_d.m_yx      = m_q[3];
      out_d.m_yy      = m_q[4];
      out_d.m_ty      = m_q[5];
      out_d.point_x   = px_q;
      out_d.point_y   = py_q;
      out_d.error     = err_q;
    end
  end

  assign in_stall_o  = (state_q != atf_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_refused_no_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.error) |-> (out_data_o.point_x == 0 && out_data_o.point_y == 0))
    else $error("refused command carries a point result");

  a_entry_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == atf_pkg::ST_MAC3) |-> (k_q <= 3'd5))
    else $error("multiply-add entry index out of range");

  a_point_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == atf_pkg::ST_MAC3 && mode_q != atf_pkg::MD_APPLY) |-> (k_q <= 3'd1))
    else $error("point or rotation pass ran past two entries");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == atf_pkg::ST_DONE))
    else $error("result beat raised outside the completion state");
`endif

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the affine transform accumulator.
module tb;

  localparam int STEPS = 24;
  localparam int FB    = 16;
  localparam longint GAIN = 64'sd652032874;

  // atan(2^-i) in Q30 degrees, used by the local sine/cosine predictor
  localparam longint ATAN_Q30 [32] = '{
    64'sd48318382080, 64'sd28524006506, 64'sd15071301663, 64'sd7650428051,
    64'sd3840059796,  64'sd1921901881,  64'sd961185452,   64'sd480622056,
    64'sd240314695,   64'sd120157806,   64'sd60078960,    64'sd30039487,
    64'sd15019745,    64'sd7509872,     64'sd3754936,     64'sd1877468,
    64'sd938734,      64'sd469367,      64'sd234684,      64'sd117342,
    64'sd58671,       64'sd29335,       64'sd14668,       64'sd7334,
    64'sd3667,        64'sd1833,        64'sd917,         64'sd458,
    64'sd229,         64'sd115,         64'sd57,          64'sd29
  };

  logic     clk_i, rst_ni;
  logic     in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  atf_pkg::atf_in_t  in_data_i;
  atf_pkg::atf_out_t out_data_o;

  int unsigned send_idle_pct, recv_idle_pct;

  affine_transform_accumulator DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  // Floor shift for signed 64-bit values
  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Two halved products plus the offset, rounded at the Q.F point
  function automatic longint mul_add(longint a, longint b, longint c, longint d, longint e);
    longint acc;
    acc = asr(a * b, 1) + asr(c * d, 1) + e * (64'sd1 <<< (FB - 1));
    return sat32(rnd_shift(acc, FB - 1));
  endfunction

  class matrix_scoreboard;
    logic signed [31:0] mat [6];
    atf_pkg::atf_out_t pending [$];
    int errors;

    function new();
      reset_matrix();
      errors = 0;
    endfunction

    function void reset_matrix();
      foreach (mat[i]) mat[i] = '0;
      mat[0] = 32'sd1 <<< FB;
      mat[4] = 32'sd1 <<< FB;
    endfunction

    // Sine and cosine in Q30 of an angle in Q.F degrees
    function void sin_cos(longint deg, output longint sn, output longint cs);
      longint full_turn, half_turn, quarter, r, x, y, z, dx, dy;
      bit flip;
      full_turn = longint'(360) <<< FB;
      half_turn = longint'(180) <<< FB;
      quarter   = (longint'(180) <<< 30) / 2;
      r = deg % full_turn;
      if (r >= half_turn) r -= full_turn;
      if (r < -half_turn) r += full_turn;
      z = r * (64'sd1 <<< (30 - FB));
      flip = 0;
      if (z > quarter) begin
        z -= 2 * quarter; flip = 1;
      end else if (z < -quarter) begin
        z += 2 * quarter; flip = 1;
      end
      x = GAIN; y = 0;
      for (int i = 0; i < STEPS && i < 32; i++) begin
        dx = asr(y, i); dy = asr(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= ATAN_Q30[i];
        end else begin
          x += dx; y -= dy; z += ATAN_Q30[i];
        end
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
    endfunction

    function void compose(longint t[6]);
      longint m[6], r[6];
      foreach (m[i]) m[i] = mat[i];
      r[0] = mul_add(t[0], m[0], t[1], m[3], 0);
      r[1] = mul_add(t[0], m[1], t[1], m[4], 0);
      r[2] = mul_add(t[0], m[2], t[1], m[5], t[2]);
      r[3] = mul_add(t[3], m[0], t[4], m[3], 0);
      r[4] = mul_add(t[3], m[1], t[4], m[4], 0);
      r[5] = mul_add(t[3], m[2], t[4], m[5], t[5]);
      foreach (r[i]) mat[i] = r[i][31:0];
    endfunction

    // Note an accepted command beat and queue the matrix it leads to
    function void note_command(atf_pkg::atf_in_t cmd);
      longint a, b, c, one, sn, cs, px, py;
      longint t[6];
      atf_pkg::atf_out_t res;
      bit err;
      a = cmd.arg_a; b = cmd.arg_b; c = cmd.arg_c;
      one = 64'sd1 <<< FB;
      t = '{one, 0, 0, 0, one, 0};
      px = 0; py = 0; err = 0;
      case (cmd.operation)
        atf_pkg::OP_IDENTITY:  reset_matrix();
        atf_pkg::OP_TRANSLATE: begin
          t[2] = a; t[5] = b; compose(t);
        end
        atf_pkg::OP_SCALE: begin
          t[0] = a; t[4] = b; compose(t);
        end
        atf_pkg::OP_ROTATE: begin
          sin_cos(a, sn, cs);
          cs = rnd_shift(cs, 30 - FB);
          sn = rnd_shift(sn, 30 - FB);
          t[0] = cs; t[1] = -sn; t[3] = sn; t[4] = cs;
          t[2] = sat32(rnd_shift(b * one - cs * b + sn * c, FB));
          t[5] = sat32(rnd_shift(c * one - sn * b - cs * c, FB));
          compose(t);
        end
        atf_pkg::OP_XSKEW, atf_pkg::OP_YSKEW: begin
          sin_cos(a, sn, cs);
          if ((cs < 0 ? -cs : cs) < (64'sd1 <<< (30 - FB))) err = 1;
          else begin
            if (cmd.operation == atf_pkg::OP_XSKEW) t[1] = sat32((sn * one) / cs);
            else t[3] = sat32((sn * one) / cs);
            compose(t);
          end
        end
        atf_pkg::OP_MIRROR_H: begin
          t[4] = -one; t[5] = sat32(2 * a); compose(t);
        end
        atf_pkg::OP_MIRROR_V: begin
          t[0] = -one; t[2] = sat32(2 * a); compose(t);
        end
        atf_pkg::OP_MATRIX: begin
          t[0] = a; t[1] = b; t[2] = c;
          t[3] = cmd.arg_d; t[4] = cmd.arg_e; t[5] = cmd.arg_f;
          compose(t);
        end
        atf_pkg::OP_POINT: begin
          px = mul_add(mat[0], a, mat[1], b, mat[2]);
          py = mul_add(mat[3], a, mat[4], b, mat[5]);
        end
        default: err = 1;
      endcase
      res.m_xx = mat[0]; res.m_xy = mat[1]; res.m_tx = mat[2];
      res.m_yx = mat[3]; res.m_yy = mat[4]; res.m_ty = mat[5];
      res.point_x = px[31:0]; res.point_y = py[31:0]; res.error = err;
      pending.push_back(res);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    // Compare a result beat against the oldest expectation
    task check_result(atf_pkg::atf_out_t got);
      atf_pkg::atf_out_t want;
      if (pending.size() == 0) begin
        report("unexpected result beat", 0, 0);
        return;
      end
      want = pending.pop_front();
      if (got.m_xx !== want.m_xx) report("m_xx", got.m_xx, want.m_xx);
      if (got.m_xy !== want.m_xy) report("m_xy", got.m_xy, want.m_xy);
      if (got.m_tx !== want.m_tx) report("m_tx", got.m_tx, want.m_tx);
      if (got.m_yx !== want.m_yx) report("m_yx", got.m_yx, want.m_yx);
      if (got.m_yy !== want.m_yy) report("m_yy", got.m_yy, want.m_yy);
      if (got.m_ty !== want.m_ty) report("m_ty", got.m_ty, want.m_ty);
      if (got.point_x !== want.point_x) report("point_x", got.point_x, want.point_x);
      if (got.point_y !== want.point_y) report("point_y", got.point_y, want.point_y);
      if (got.error !== want.error) report("error", got.error, want.error);
    endtask
  endclass

  matrix_scoreboard board;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: stall at random and check each accepted result beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_result(out_data_o);
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Idle at random first, then hold the beat until accepted; valid stays up
  // after acceptance until the next idle cycle or the caller drops it
  task automatic send_command(atf_pkg::atf_in_t cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_command(cmd);
  endtask

  task automatic send_op(atf_pkg::atf_op_e op, int a, int b = 0, int c = 0,
                         int d = 0, int e = 0, int f = 0);
    atf_pkg::atf_in_t cmd;
    cmd = '{operation: op, arg_a: a, arg_b: b, arg_c: c, arg_d: d, arg_e: e, arg_f: f};
    send_command(cmd);
  endtask

  function automatic int rand_q(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  // Mostly modest values so the matrix keeps meaningful bits, some full range
  function automatic atf_pkg::atf_in_t random_command();
    atf_pkg::atf_in_t cmd;
    int unsigned pick;
    cmd.arg_a = $urandom; cmd.arg_b = $urandom; cmd.arg_c = $urandom;
    cmd.arg_d = $urandom; cmd.arg_e = $urandom; cmd.arg_f = $urandom;
    pick = $urandom_range(99);
    if (pick < 4) cmd.operation = 4'($urandom_range(15, 10));
    else if (pick < 8) cmd.operation = atf_pkg::OP_IDENTITY;
    else cmd.operation = 4'($urandom_range(9, 1));
    if ($urandom_range(99) < 80) begin
      cmd.arg_a = rand_q(32'h0003_0000); cmd.arg_b = rand_q(32'h0003_0000);
      cmd.arg_c = rand_q(32'h0003_0000); cmd.arg_d = rand_q(32'h0003_0000);
      cmd.arg_e = rand_q(32'h0003_0000); cmd.arg_f = rand_q(32'h0003_0000);
      if (cmd.operation inside {atf_pkg::OP_ROTATE, atf_pkg::OP_XSKEW, atf_pkg::OP_YSKEW})
        cmd.arg_a = rand_q(32'h02D0_0000);
      if (cmd.operation == atf_pkg::OP_POINT || cmd.operation == atf_pkg::OP_TRANSLATE) begin
        cmd.arg_a = rand_q(32'h0100_0000); cmd.arg_b = rand_q(32'h0100_0000);
      end
    end
    return cmd;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) send_command(random_command());
  endtask

  initial begin
    board = new();
    rst_ni = 0; in_valid_i = 0; in_data_i = '0; out_stall_i = 0;
    send_idle_pct = 10; recv_idle_pct = 87;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: every operation, field extremes, skew at the poles, bad opcodes
    send_op(atf_pkg::OP_POINT, 32'sh0001_8000, -32'sh0002_0000);
    send_op(atf_pkg::OP_TRANSLATE, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_op(atf_pkg::OP_POINT, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_op(atf_pkg::OP_IDENTITY, -1, -1, -1, -1, -1, -1);
    send_op(atf_pkg::OP_SCALE, 32'sh0002_0000, -32'sh0000_8000);
    send_op(atf_pkg::OP_ROTATE, 32'sh005A_0000, 32'sh0001_0000, 32'sh0002_0000);
    send_op(atf_pkg::OP_ROTATE, -32'sh00B4_0000, 0, 0);
    send_op(atf_pkg::OP_ROTATE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_op(atf_pkg::OP_XSKEW, 32'sh005A_0000);
    send_op(atf_pkg::OP_YSKEW, -32'sh005A_0000);
    send_op(atf_pkg::OP_XSKEW, 32'sh010E_0000);
    send_op(atf_pkg::OP_XSKEW, 32'sh002D_0000);
    send_op(atf_pkg::OP_YSKEW, 32'sh0059_FFFF);
    send_op(atf_pkg::OP_MIRROR_H, 32'sh7FFF_FFFF);
    send_op(atf_pkg::OP_MIRROR_V, 32'sh8000_0000);
    send_op(atf_pkg::OP_MATRIX, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
            32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_op(atf_pkg::OP_POINT, 32'sh0001_0000, 32'sh0001_0000);
    send_op(atf_pkg::atf_op_e'(4'd10), 1, 2, 3, 4, 5, 6);
    send_op(atf_pkg::atf_op_e'(4'd15), -1, -1, -1, -1, -1, -1);
    send_op(atf_pkg::OP_IDENTITY, 0);
    send_op(atf_pkg::OP_MIRROR_H, 32'sh0001_0000);
    send_op(atf_pkg::OP_MIRROR_V, -32'sh0001_0000);

    run_random(170);
    // Pause the sender until the block has drained everything
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    send_idle_pct = 87; recv_idle_pct = 10;
    run_random(170);
    send_idle_pct = 0; recv_idle_pct = 0;
    run_random(190);

    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Watchdog: generous bound well beyond the slowest legal run
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/atf_pkg.sv
rtl/atf_cordic.sv
rtl/atf_div.sv
rtl/atf_mac.sv
rtl/affine_transform_accumulator.sv
tb/sv/tb.sv
